/* sv/ufp_pkg.sv */
// Shared types and constants for the UBX frame parser.
// Used by every parser module but the RAM, and by the testbench; depends on nothing.
package ufp_pkg;

  localparam int BYTE_W      = 8;
  localparam int POS_W       = 7;
  localparam int LEN_W       = 16;
  localparam int IDX_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int HDR_BYTES   = 4;
  localparam int BUF_LEN_DEF = 64;

  // Byte positions within a frame
  localparam logic [POS_W-1:0] POS_HUNT   = 7'd0;
  localparam logic [POS_W-1:0] POS_SYNC2  = 7'd1;
  localparam logic [POS_W-1:0] POS_CLASS  = 7'd2;
  localparam logic [POS_W-1:0] POS_ID     = 7'd3;
  localparam logic [POS_W-1:0] POS_LEN_LO = 7'd4;
  localparam logic [POS_W-1:0] POS_LEN_HI = 7'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ID_ZERO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ID_ONE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ID_TWO      = 3'd5;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'hB5;
  localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'h62;
  localparam logic [BYTE_W-1:0] RST_CLASS       = 8'h01;
  localparam logic [BYTE_W-1:0] RST_ID_ZERO     = 8'h02;
  localparam logic [BYTE_W-1:0] RST_ID_ONE      = 8'h03;
  localparam logic [BYTE_W-1:0] RST_ID_TWO      = 8'h12;

  // Matched id indexes
  localparam logic [IDX_W-1:0] IDX_ZERO = 2'd0;
  localparam logic [IDX_W-1:0] IDX_ONE  = 2'd1;
  localparam logic [IDX_W-1:0] IDX_TWO  = 2'd2;

  // Request from the parser to the output sequencer
  typedef struct packed {
    logic             start;
    logic             error;
    logic [IDX_W-1:0] index;
  } ufp_req_t;

endpackage

/* sv/ufp_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ufp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/ufp_parse.sv */
// Byte parser: sync hunt, header checks, frame store writes, Fletcher-8 sum.
// Depends on ufp_pkg; holds the configuration registers.
module ufp_parse #(
  parameter int BUF_LEN = ufp_pkg::BUF_LEN_DEF,
  parameter int AW      = $clog2(BUF_LEN)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [ufp_pkg::BYTE_W-1:0]     rx_byte,
  input  logic                           cfg_we,
  input  logic [ufp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ufp_pkg::BYTE_W-1:0]     cfg_data,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [ufp_pkg::BYTE_W-1:0]     mem_wdata,
  output ufp_pkg::ufp_req_t              req,
  output logic [AW-1:0]                  last_addr
);
  import ufp_pkg::*;

  localparam int FL_W = LEN_W + 1;

  logic [BYTE_W-1:0] sync_first, sync_second, class_accept;
  logic [BYTE_W-1:0] id_zero, id_one, id_two;

  logic [POS_W-1:0]  pos, pos_next;
  logic [BYTE_W-1:0] len_low, len_low_next;
  logic [LEN_W-1:0]  payload_length, payload_length_next;
  logic [IDX_W-1:0]  matched, matched_next;
  logic [BYTE_W-1:0] sum_a, sum_a_next, sum_b, sum_b_next;
  logic              phase, phase_next;

  logic [POS_W-1:0]  at;
  logic [FL_W-1:0]   frame_len;
  logic              in_body;
  logic [BYTE_W-1:0] chk;
  logic              hunt;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first   <= RST_SYNC_FIRST;
      sync_second  <= RST_SYNC_SECOND;
      class_accept <= RST_CLASS;
      id_zero      <= RST_ID_ZERO;
      id_one       <= RST_ID_ONE;
      id_two       <= RST_ID_TWO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_FIRST:  sync_first   <= cfg_data;
        REG_SYNC_SECOND: sync_second  <= cfg_data;
        REG_CLASS:       class_accept <= cfg_data;
        REG_ID_ZERO:     id_zero      <= cfg_data;
        REG_ID_ONE:      id_one       <= cfg_data;
        REG_ID_TWO:      id_two       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign at        = pos - POS_CLASS;
  assign frame_len = FL_W'(payload_length) + FL_W'(HDR_BYTES);
  assign in_body   = FL_W'(at) < frame_len;
  assign chk       = phase ? sum_b : sum_a;
  assign mem_waddr = at[AW-1:0];
  assign last_addr = AW'(at - 7'd1);

  always_comb begin
    pos_next            = pos;
    len_low_next        = len_low;
    payload_length_next = payload_length;
    matched_next        = matched;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    phase_next          = phase;
    mem_we              = 1'b0;
    mem_wdata           = rx_byte;
    req                 = '0;
    req.index           = matched;
    hunt                = 1'b0;

    if (accept) begin
      case (pos)
        POS_HUNT: begin
          if (rx_byte == sync_first) pos_next = POS_SYNC2;
        end
        POS_SYNC2: begin
          pos_next = (rx_byte == sync_second) ? POS_CLASS : POS_HUNT;
        end
        POS_CLASS: begin
          mem_we    = 1'b1;
          mem_wdata = (rx_byte == class_accept) ? rx_byte : '0;
          pos_next  = POS_ID;
        end
        POS_ID: begin
          mem_we = 1'b1;
          if (rx_byte == id_zero) begin
            matched_next = IDX_ZERO;
          end else if (rx_byte == id_one) begin
            matched_next = IDX_ONE;
          end else if (rx_byte == id_two) begin
            matched_next = IDX_TWO;
          end else begin
            matched_next = IDX_ZERO;
            mem_wdata    = '0;
          end
          pos_next = POS_LEN_LO;
        end
        POS_LEN_LO: begin
          mem_we       = 1'b1;
          len_low_next = rx_byte;
          pos_next     = POS_LEN_HI;
        end
        POS_LEN_HI: begin
          mem_we              = 1'b1;
          payload_length_next = {rx_byte, len_low};
          pos_next            = pos + 7'd1;
        end
        default: begin
          if (in_body) begin
            mem_we   = 1'b1;
            pos_next = pos + 7'd1;
          end else if (rx_byte == chk) begin
            if (phase) begin
              req.start = 1'b1;
              hunt      = 1'b1;
            end else begin
              phase_next = 1'b1;
            end
          end else begin
            req.start = 1'b1;
            req.error = 1'b1;
            hunt      = 1'b1;
          end
        end
      endcase

      // Running Fletcher-8 over each stored byte; the class byte restarts it
      if (mem_we) begin
        if (pos == POS_CLASS) begin
          sum_a_next = mem_wdata;
          sum_b_next = mem_wdata;
        end else begin
          sum_a_next = sum_a + mem_wdata;
          sum_b_next = sum_b + sum_a_next;
        end
      end

      if (hunt || pos_next > POS_W'(BUF_LEN)) begin
        pos_next            = POS_HUNT;
        payload_length_next = '0;
        matched_next        = IDX_ZERO;
        phase_next          = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= POS_HUNT;
      payload_length <= '0;
      matched        <= IDX_ZERO;
      sum_a          <= '0;
      sum_b          <= '0;
      phase          <= 1'b0;
    end else begin
      pos            <= pos_next;
      payload_length <= payload_length_next;
      matched        <= matched_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      phase          <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    len_low <= len_low_next;
  end

endmodule

/* sv/ufp_dump.sv */
// Output sequencer: reads the frame store back byte by byte, or sends one
// error result, into the output register. Depends on ufp_pkg.
module ufp_dump #(
  parameter int BUF_LEN = ufp_pkg::BUF_LEN_DEF,
  parameter int AW      = $clog2(BUF_LEN)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ufp_pkg::ufp_req_t             req,
  input  logic [AW-1:0]                 last_addr,
  output logic                          busy,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [ufp_pkg::BYTE_W-1:0]    mem_rdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ufp_pkg::BYTE_W-1:0]    m_tdata,
  output logic [ufp_pkg::IDX_W:0]       m_tuser,
  output logic                          m_tlast
);
  import ufp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ERR  = 4'b0010,
    ST_READ = 4'b0100,
    ST_WAIT = 4'b1000
  } ufp_state_t;

  ufp_state_t        state, state_next;
  logic [AW-1:0]     rd_addr, rd_addr_next;
  logic [AW-1:0]     end_addr;
  logic [IDX_W-1:0]  index;
  logic              out_free;
  logic              load;
  logic [BYTE_W-1:0] load_data;
  logic [IDX_W:0]    load_user;
  logic              load_last;

  assign busy      = (state != ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign mem_re    = (state == ST_READ);
  assign mem_raddr = rd_addr;

  always_comb begin
    state_next   = state;
    rd_addr_next = rd_addr;
    load         = 1'b0;
    load_data    = mem_rdata;
    load_user    = {1'b0, index};
    load_last    = (rd_addr == end_addr);
    case (state)
      ST_IDLE: begin
        if (req.start) begin
          rd_addr_next = '0;
          state_next   = req.error ? ST_ERR : ST_READ;
        end
      end
      ST_ERR: begin
        load_data = '0;
        load_user = {1'b1, IDX_ZERO};
        load_last = 1'b1;
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        // read data holds until the next read, so wait on the output here
        if (out_free) begin
          load = 1'b1;
          if (load_last) begin
            state_next = ST_IDLE;
          end else begin
            rd_addr_next = rd_addr + AW'(1);
            state_next   = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= rd_addr_next;
    if (state == ST_IDLE && req.start) begin
      end_addr <= last_addr;
      index    <= req.index;
    end
    if (load) begin
      m_tdata <= load_data;
      m_tuser <= load_user;
      m_tlast <= load_last;
    end
  end

endmodule

/* sv/ubx_frame_parser_unit.sv */
// UBX frame parser with Fletcher-8 check. A byte that completes no frame is
// taken back to back while no result is in flight. A failed check loads its
// error result via the error state into the output register; a verified frame
// holds off input during readback, a read and a wait state per stored byte on
// the store's single registered read port. Synchronous active-high reset sets
// the sync/class/id registers to their defaults and returns to sync hunting.
module ubx_frame_parser_unit #(
  parameter int BUF_LEN = ufp_pkg::BUF_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input byte stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ufp_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ufp_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] frame_byte
  output logic [ufp_pkg::IDX_W:0]       m_tuser,   // [1:0] message_index, [2] result_status
  output logic                          m_tlast,   // last_of_run
  // configuration writes
  input  logic                          cfg_we,
  input  logic [ufp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ufp_pkg::BYTE_W-1:0]    cfg_data
);
  import ufp_pkg::*;

  localparam int AW = $clog2(BUF_LEN);

  logic              accept;
  logic              busy;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  ufp_req_t          req;
  logic [AW-1:0]     last_addr;

  // Hold input only while a frame readback or an error result is in flight;
  // a result waiting in the output register does not stall the parser.
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  // Header checks, store writes and the running checksum
  ufp_parse #(
    .BUF_LEN (BUF_LEN),
    .AW      (AW)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .req       (req),
    .last_addr (last_addr)
  );

  // Frame store: class, id, length, payload. Writes come only while the
  // readback is idle, so the two ports never touch the same entry at once.
  ufp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_LEN)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Readback of a verified frame, or the single error result
  ufp_dump #(
    .BUF_LEN (BUF_LEN),
    .AW      (AW)
  ) u_dump (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .last_addr (last_addr),
    .busy      (busy),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

/* sim/tb.sv */
// Testbench for ubx_frame_parser_unit: streams sync-framed UBX bytes and random noise,
// predicts each output request with its own parser model and checks the requests in order.
// Depends on ufp_pkg and the parser RTL.
module tb;
  import ufp_pkg::*;

  localparam int FRAME_BUF_DEPTH = 64;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int IDLE_PCT        = 19;
  localparam int PHASE_BYTES     = 4;

  // Output status codes
  localparam logic ST_FRAME  = 1'b0;
  localparam logic ST_CKFAIL = 1'b1;

  // Ways to spoil the check bytes of a generated frame
  localparam int SPOIL_NONE = 0;
  localparam int SPOIL_CK_A = 1;
  localparam int SPOIL_CK_B = 2;

  // Register indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  msg_idx;
    logic              status;
    logic              tlast_bit;
  } frame_out_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [BYTE_W-1:0]    m_tdata;
  logic [IDX_W:0]       m_tuser;
  logic                 m_tlast;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SYNC_FIRST;
  logic [BYTE_W-1:0]    cfg_data  = '0;

  ubx_frame_parser_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser model: mirrors the register file and the frame state, and queues the
  // output requests that each accepted byte causes.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] accept_reg [0:5];
  logic [POS_W-1:0]  hunt_pos;
  logic [BYTE_W-1:0] frame_buf [0:FRAME_BUF_DEPTH-1];
  logic [LEN_W-1:0]  body_len;
  logic [IDX_W-1:0]  id_slot;
  logic [BYTE_W-1:0] fl_a, fl_b;
  logic              want_ck_b;
  frame_out_t        awaited_out [$];
  int                mismatch_count = 0;

  task automatic restart_hunt();
    hunt_pos  = POS_HUNT;
    body_len  = '0;
    id_slot   = IDX_ZERO;
    want_ck_b = 1'b0;
  endtask

  task automatic fletcher_over(input int count);
    fl_a = '0;
    fl_b = '0;
    for (int i = 0; i < count && i < FRAME_BUF_DEPTH; i++) begin
      fl_a = fl_a + frame_buf[i];
      fl_b = fl_b + fl_a;
    end
  endtask

  task automatic parse_byte(input logic [BYTE_W-1:0] c);
    int         frame_len;
    int         at;
    int         cnt;
    frame_out_t r;
    frame_len = int'(body_len) + HDR_BYTES;
    case (hunt_pos)
      POS_HUNT: begin
        if (c == accept_reg[REG_SYNC_FIRST]) hunt_pos = POS_SYNC2;
      end
      POS_SYNC2: begin
        // a wrong second sync byte is dropped, not re-tested as a first one
        hunt_pos = (c == accept_reg[REG_SYNC_SECOND]) ? POS_CLASS : POS_HUNT;
      end
      POS_CLASS: begin
        frame_buf[0] = (c == accept_reg[REG_CLASS]) ? c : '0;
        hunt_pos = POS_ID;
      end
      POS_ID: begin
        // lowest index wins when id registers are equal
        if (c == accept_reg[REG_ID_ZERO]) begin
          frame_buf[1] = c;
          id_slot = IDX_ZERO;
        end else if (c == accept_reg[REG_ID_ONE]) begin
          frame_buf[1] = c;
          id_slot = IDX_ONE;
        end else if (c == accept_reg[REG_ID_TWO]) begin
          frame_buf[1] = c;
          id_slot = IDX_TWO;
        end else begin
          frame_buf[1] = '0;
          id_slot = IDX_ZERO;
        end
        hunt_pos = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        frame_buf[2] = c;
        hunt_pos = POS_LEN_HI;
      end
      POS_LEN_HI: begin
        frame_buf[3] = c;
        body_len = {c, frame_buf[2]};
        if (body_len == '0) fletcher_over(HDR_BYTES);
        hunt_pos = POS_LEN_HI + 7'd1;
      end
      default: begin
        at = int'(hunt_pos) - 2;
        if (at < frame_len) begin
          if (at < BUF_LEN_DEF) frame_buf[at] = c;
          if (at == frame_len - 1) fletcher_over(frame_len);
          hunt_pos = hunt_pos + 7'd1;
        end else if (c == (want_ck_b ? fl_b : fl_a)) begin
          if (want_ck_b) begin
            cnt = (frame_len > FRAME_BUF_DEPTH) ? FRAME_BUF_DEPTH : frame_len;
            for (int i = 0; i < cnt; i++) begin
              r.frame_byte = frame_buf[i];
              r.msg_idx    = id_slot;
              r.status     = ST_FRAME;
              r.tlast_bit  = (i == cnt - 1);
              awaited_out.push_back(r);
            end
            restart_hunt();
            return;
          end
          want_ck_b = 1'b1;
        end else begin
          r.frame_byte = '0;
          r.msg_idx    = IDX_ZERO;
          r.status     = ST_CKFAIL;
          r.tlast_bit  = 1'b1;
          awaited_out.push_back(r);
          restart_hunt();
          return;
        end
      end
    endcase
    // overrun: drop the frame without any result
    if (hunt_pos > BUF_LEN_DEF) restart_hunt();
  endtask

  task automatic note_mismatch(input string why, input frame_out_t got,
                               input frame_out_t want);
    mismatch_count++;
    $display("frame out %s: got byte %h idx %0d st %0b last %0b, want %h %0d %0b %0b",
             why, got.frame_byte, got.msg_idx, got.status, got.tlast_bit,
             want.frame_byte, want.msg_idx, want.status, want.tlast_bit);
  endtask

  task automatic check_out();
    frame_out_t got;
    frame_out_t want;
    got.frame_byte = m_tdata;
    got.msg_idx    = m_tuser[IDX_W-1:0];
    got.status     = m_tuser[IDX_W];
    got.tlast_bit  = m_tlast;
    if (awaited_out.size() == 0) begin
      note_mismatch("with nothing awaited", got, '0);
    end else begin
      want = awaited_out.pop_front();
      if (got.frame_byte != want.frame_byte || got.msg_idx != want.msg_idx ||
          got.status != want.status || got.tlast_bit != want.tlast_bit)
        note_mismatch("differs", got, want);
    end
  endtask

  // Monitor: sample both streams and the config port at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      accept_reg[REG_SYNC_FIRST]  = RST_SYNC_FIRST;
      accept_reg[REG_SYNC_SECOND] = RST_SYNC_SECOND;
      accept_reg[REG_CLASS]       = RST_CLASS;
      accept_reg[REG_ID_ZERO]     = RST_ID_ZERO;
      accept_reg[REG_ID_ONE]      = RST_ID_ONE;
      accept_reg[REG_ID_TWO]      = RST_ID_TWO;
      fl_a = '0;
      fl_b = '0;
      restart_hunt();
    end else begin
      if (m_tvalid && m_tready) check_out();
      if (s_tvalid && s_tready) parse_byte(s_tdata);
      if (cfg_we && cfg_index <= REG_ID_TWO) accept_reg[cfg_index] = cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] outgoing_bytes [$];
  logic              byte_taken = 1'b0;
  logic              steady     = 1'b0;
  logic              hold_req   = 1'b0;
  logic              hold_done  = 1'b0;
  int                hold_count = 0;
  int                quiet_cycles = 0;

  always @(posedge clk) begin
    byte_taken <= !rst && s_tvalid && s_tready;
  end

  // Advance to the next byte once the current one is taken; idle at random.
  always @(negedge clk) begin
    if (!s_tvalid || byte_taken) begin
      if (outgoing_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= outgoing_bytes.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result stream at random; hold it off for one long stretch on request.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("ubx_frame_parser_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] gen_reg [0:5];

  task automatic wait_drained(input int settle);
    while (outgoing_bytes.size() != 0 || s_tvalid || awaited_out.size() != 0)
      @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_ID_TWO) gen_reg[idx] = val;
  endtask

  task automatic write_all(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                           input logic [BYTE_W-1:0] cl, input logic [BYTE_W-1:0] i0,
                           input logic [BYTE_W-1:0] i1, input logic [BYTE_W-1:0] i2);
    wait_drained(SETTLE_CYCLES);
    write_reg(REG_SYNC_FIRST, s1);
    write_reg(REG_SYNC_SECOND, s2);
    write_reg(REG_CLASS, cl);
    write_reg(REG_ID_ZERO, i0);
    write_reg(REG_ID_ONE, i1);
    write_reg(REG_ID_TWO, i2);
  endtask

  // Queue one frame with its Fletcher-8 check over the bytes as sent.
  task automatic send_frame(input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] idv,
                            input logic [LEN_W-1:0] plen, input int spoil);
    logic [BYTE_W-1:0] body [$];
    logic [BYTE_W-1:0] ck_a;
    logic [BYTE_W-1:0] ck_b;
    int                n;
    body.push_back(cls);
    body.push_back(idv);
    body.push_back(plen[7:0]);
    body.push_back(plen[15:8]);
    n = (plen > 16'd60) ? 60 : int'(plen);
    repeat (n) body.push_back(BYTE_W'($urandom_range(255)));
    ck_a = '0;
    ck_b = '0;
    foreach (body[i]) begin
      ck_a = ck_a + body[i];
      ck_b = ck_b + ck_a;
    end
    if (spoil == SPOIL_CK_A) ck_a = ck_a ^ BYTE_W'($urandom_range(255, 1));
    if (spoil == SPOIL_CK_B) ck_b = ck_b ^ BYTE_W'($urandom_range(255, 1));
    outgoing_bytes.push_back(gen_reg[REG_SYNC_FIRST]);
    outgoing_bytes.push_back(gen_reg[REG_SYNC_SECOND]);
    foreach (body[i]) outgoing_bytes.push_back(body[i]);
    outgoing_bytes.push_back(ck_a);
    outgoing_bytes.push_back(ck_b);
  endtask

  // Mostly well-formed frames with random content, some broken syncs and noise.
  task automatic random_traffic(input int goal);
    int                made;
    int                roll;
    logic [BYTE_W-1:0] cls;
    logic [BYTE_W-1:0] idv;
    logic [LEN_W-1:0]  plen;
    int                spoil;
    made = 0;
    while (made < goal) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        cls = ($urandom_range(9) == 0) ? BYTE_W'($urandom_range(255)) : gen_reg[REG_CLASS];
        case ($urandom_range(3))
          0:       idv = gen_reg[REG_ID_ZERO];
          1:       idv = gen_reg[REG_ID_ONE];
          2:       idv = gen_reg[REG_ID_TWO];
          default: idv = BYTE_W'($urandom_range(255));
        endcase
        plen = ($urandom_range(19) == 0) ? LEN_W'($urandom_range(58, 7))
                                         : LEN_W'($urandom_range(6));
        spoil = ($urandom_range(9) == 0) ? $urandom_range(SPOIL_CK_B, SPOIL_CK_A)
                                         : SPOIL_NONE;
        send_frame(cls, idv, plen, spoil);
        made += int'(plen) + 8;
      end else if (roll < 85) begin
        // first sync followed by a wrong second sync
        outgoing_bytes.push_back(gen_reg[REG_SYNC_FIRST]);
        outgoing_bytes.push_back(gen_reg[REG_SYNC_SECOND] ^ BYTE_W'($urandom_range(255, 1)));
        made += 2;
      end else begin
        repeat ($urandom_range(3, 1)) outgoing_bytes.push_back(BYTE_W'($urandom_range(255)));
      end
      // now and then pause the sender until every result is in
      if ($urandom_range(15) == 0) wait_drained(0);
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] pick;
    gen_reg[REG_SYNC_FIRST]  = RST_SYNC_FIRST;
    gen_reg[REG_SYNC_SECOND] = RST_SYNC_SECOND;
    gen_reg[REG_CLASS]       = RST_CLASS;
    gen_reg[REG_ID_ZERO]     = RST_ID_ZERO;
    gen_reg[REG_ID_ONE]      = RST_ID_ONE;
    gen_reg[REG_ID_TWO]      = RST_ID_TWO;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme noise bytes, then a repeated first sync, which must
    // not restart the frame, then a zero-length frame on default registers.
    outgoing_bytes.push_back(8'h00);
    outgoing_bytes.push_back(8'hFF);
    outgoing_bytes.push_back(RST_SYNC_FIRST);
    outgoing_bytes.push_back(RST_SYNC_FIRST);
    outgoing_bytes.push_back(RST_SYNC_SECOND);
    send_frame(RST_CLASS, RST_ID_ZERO, 16'd0, SPOIL_NONE);

    // Random registers with two equal ids.
    pick = BYTE_W'($urandom_range(255, 1));
    write_all(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
              BYTE_W'($urandom_range(255, 1)), pick, pick, BYTE_W'($urandom_range(255, 1)));
    random_traffic(PHASE_BYTES);

    // Extremes one way; the spare indexes must change nothing.
    write_all(8'h00, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF);
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h00);
    random_traffic(PHASE_BYTES);

    // Extremes the other way, with a payload length that overruns the buffer.
    write_all(8'hFF, 8'h00, 8'h01, 8'hFF, 8'h80, 8'h01);
    random_traffic(PHASE_BYTES);
    send_frame(gen_reg[REG_CLASS], gen_reg[REG_ID_ZERO], 16'hFFFF, SPOIL_NONE);

    // Hold the result stream off while frames keep coming in; the first frame
    // fills the output and the second one waits at the input.
    write_all(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
              BYTE_W'($urandom_range(255, 1)), BYTE_W'($urandom_range(255, 1)),
              BYTE_W'($urandom_range(255, 1)), BYTE_W'($urandom_range(255, 1)));
    hold_req = 1'b1;
    send_frame(gen_reg[REG_CLASS], gen_reg[REG_ID_ONE], 16'd2, SPOIL_NONE);
    send_frame(gen_reg[REG_CLASS], gen_reg[REG_ID_TWO], 16'd0, SPOIL_CK_B);

    // Back to the reset values, with no idling on either side, ending on the
    // largest frame that fits.
    write_all(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_CLASS, RST_ID_ZERO, RST_ID_ONE,
              RST_ID_TWO);
    steady = 1'b1;
    random_traffic(PHASE_BYTES);
    send_frame(gen_reg[REG_CLASS], gen_reg[REG_ID_TWO], 16'd58, SPOIL_NONE);

    wait_drained(10);
    if (mismatch_count == 0 && awaited_out.size() == 0) begin
      $display("ubx_frame_parser_unit: match");
    end else begin
      $display("ubx_frame_parser_unit: mismatch");
    end
    $finish;
  end

endmodule
